FILE: rtl/skt_pkg.sv
package skt_pkg;

    localparam int KEY_W        = 17;
    localparam int CAPACITY_DEF = 64;

    typedef logic [KEY_W-1:0] t_key;

    localparam t_key KEY_MAX = t_key'(99999);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_DELETE = 2'd1;
    localparam t_cmd CMD_SEARCH = 2'd2;

    typedef logic [2:0] t_status;
    localparam t_status ST_DONE    = 3'd0;
    localparam t_status ST_FULL    = 3'd1;
    localparam t_status ST_DUP     = 3'd2;
    localparam t_status ST_MISSING = 3'd3;
    localparam t_status ST_INVALID = 3'd4;

    // broadcast from the control to every cell
    typedef struct packed {
        logic ins;
        logic del;
        t_key key;
    } t_cell_ctl;

endpackage

FILE: rtl/skt_cell.sv
module skt_cell
    import skt_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occ,
    input  t_key      i_left_key,
    input  logic      i_left_lt,
    input  t_key      i_right_key,
    output t_key      o_key,
    output logic      o_lt,
    output logic      o_eq
);

    t_key r_key;
    t_key n_key;

    assign o_key = r_key;
    assign o_lt  = i_occ && (r_key < i_ctl.key);
    assign o_eq  = i_occ && (r_key == i_ctl.key);

    // slots at or above the insert point move up, at or above the hit move down
    always_comb begin
        n_key = r_key;
        if (i_ctl.ins && !o_lt) begin
            n_key = i_left_lt ? i_ctl.key : i_left_key;
        end else if (i_ctl.del && !o_lt) begin
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

FILE: rtl/skt_pos_enc.sv
module skt_pos_enc #(
    parameter int N     = 64,
    parameter int POS_W = 6
) (
    input  logic [N-1:0]     i_hit,
    output logic [POS_W-1:0] o_pos
);

    // one-hot to binary, plain or-reduction
    always_comb begin
        o_pos = '0;
        for (int i = 0; i < N; i++) begin
            if (i_hit[i]) begin
                o_pos = o_pos | POS_W'(i);
            end
        end
    end

endmodule

FILE: rtl/sorted_key_table_unit.sv
// channel | direction | handshake                  | fields
// in      | input     | i_in_valid / o_in_stall    | i_cmd, i_key
// out     | output    | o_out_valid / i_out_stall  | o_status, o_position, o_fill_count
//
// a command is captured at the in beat; in the busy step after it, every cell
// compares its key and shifts in parallel and the result is registered
// the next command is taken in the cycle the result is shown if out is not stalled
// synchronous active-low reset clears the fill count and the handshake state
// a stalled result holds the next command back; the key slots have no reset
module sorted_key_table_unit
    import skt_pkg::*;
#(
    parameter  int CAPACITY = CAPACITY_DEF,
    localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [1:0]       i_cmd,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [POS_W-1:0] o_position,
    output logic [CNT_W-1:0] o_fill_count
);

    // control and command registers
    logic             r_busy;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_cmd             r_cmd;
    t_key             r_key;
    t_status          r_status;
    t_status          n_status;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    logic w_ready;
    logic w_in_beat;

    // cell row signals
    t_key          w_cell_key [CAPACITY];
    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_sel;
    logic [CAPACITY-1:0] w_hit;
    logic [POS_W-1:0]    w_enc_pos;
    t_cell_ctl           w_ctl;

    logic w_key_ok;
    logic w_full;
    logic w_found;
    logic w_is_ins;
    logic w_do_ins;
    logic w_do_del;

    // accept only when idle and the output register is free or draining
    assign w_ready    = !r_busy && (!r_out_valid || !i_out_stall);
    assign w_in_beat  = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;

    assign w_key_ok = (r_key != '0) && (r_key <= KEY_MAX);
    assign w_full   = (r_count >= CNT_W'(CAPACITY));
    assign w_found  = |w_eq;
    assign w_is_ins = (r_cmd == CMD_INSERT);

    // decode the command into status and table update
    always_comb begin
        n_status = ST_INVALID;
        w_do_ins = 1'b0;
        w_do_del = 1'b0;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else if (!w_key_ok) begin
                    n_status = ST_INVALID;
                end else if (w_found) begin
                    n_status = ST_DUP;
                end else begin
                    n_status = ST_DONE;
                    w_do_ins = r_busy;
                end
            end
            CMD_DELETE, CMD_SEARCH: begin
                if (!w_key_ok) begin
                    n_status = ST_INVALID;
                end else if (!w_found) begin
                    n_status = ST_MISSING;
                end else begin
                    n_status = ST_DONE;
                    w_do_del = r_busy && (r_cmd == CMD_DELETE);
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    assign n_pos = (n_status == ST_DONE) ? w_enc_pos : '0;

    always_comb begin
        n_count = r_count;
        if (w_do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_del) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_ctl.ins = w_do_ins;
    assign w_ctl.del = w_do_del;
    assign w_ctl.key = r_key;

    // row of cells, each slot talks only to its two neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key w_left_key;
        t_key w_right_key;
        logic w_left_lt;
        logic w_occ;

        // nothing lies left of slot 0, so it counts as below the new key
        if (g == 0) begin : g_first
            assign w_left_key = w_cell_key[g];
            assign w_left_lt  = 1'b1;
        end else begin : g_mid
            assign w_left_key = w_cell_key[g-1];
            assign w_left_lt  = w_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_key = w_cell_key[g];
        end else begin : g_inner
            assign w_right_key = w_cell_key[g+1];
        end

        assign w_occ = (CNT_W'(g) < r_count);

        // insert slot: first slot whose key is not below the new key
        assign w_sel[g] = !w_lt[g] && w_left_lt;

        skt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (w_occ),
            .i_left_key (w_left_key),
            .i_left_lt  (w_left_lt),
            .i_right_key(w_right_key),
            .o_key      (w_cell_key[g]),
            .o_lt       (w_lt[g]),
            .o_eq       (w_eq[g])
        );
    end

    assign w_hit = w_is_ins ? w_sel : w_eq;

    skt_pos_enc #(
        .N    (CAPACITY),
        .POS_W(POS_W)
    ) u_pos_enc (
        .i_hit(w_hit),
        .o_pos(w_enc_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (w_in_beat) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_busy) begin
                r_count <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_cmd <= i_cmd;
            r_key <= i_key;
        end
        if (r_busy) begin
            r_status <= n_status;
            r_pos    <= n_pos;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_position   = r_pos;
    assign o_fill_count = r_count;

    // fill count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    // while a command executes the output register is empty
    a_busy_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_out_valid)
        else $error("result register occupied during execute");

    // stored keys are unique so at most one slot matches
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(w_eq))
        else $error("more than one slot matches the key");

    // a successful insert grows the table by one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_do_ins |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("insert did not grow the fill count");

    // a new result appears only after an execute cycle
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_busy))
        else $error("result without an executed command");

endmodule
